### design/mm_pkg.sv
// Shared types and constants for the fixed-point matrix multiply block.
// Used by the channel interfaces, the multiply-accumulate unit and the top level.
// No dependencies.
package mm_pkg;

    // Matrix shape limits and fixed-point format.
    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;
    localparam int REG_W  = 2;

    // Element stores are addressed by {row, col}.
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Product and accumulator widths; the sum of MAX_DIM products needs
    // log2(MAX_DIM) guard bits above the product width.
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_COMPUTE = 2'd2
    } t_kind;

    // Configuration register indexes.
    localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_W-1:0] REG_COLS_B    = 2'd2;

    // Reset value of each dimension register.
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Control that travels with a read pair into the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    // Finished dot product, already scaled and saturated.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
        logic             sat;
    } t_mac_res;

    // A dimension register of zero acts as one; above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

### design/mm_in_if.sv
// Input item channel of the matrix multiply block.
// Depends on mm_pkg for field widths.
interface mm_in_if;
    logic                          valid;
    logic                          ready;
    logic [mm_pkg::KIND_W-1:0]     kind;
    logic [mm_pkg::IDX_W-1:0]      row;
    logic [mm_pkg::IDX_W-1:0]      col;
    logic signed [mm_pkg::VAL_W-1:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

### design/mm_out_if.sv
// Result item channel of the matrix multiply block.
// Depends on mm_pkg for field widths.
interface mm_out_if;
    logic                            valid;
    logic                            ready;
    logic [mm_pkg::IDX_W-1:0]        out_row;
    logic [mm_pkg::IDX_W-1:0]        out_col;
    logic signed [mm_pkg::VAL_W-1:0] product_value;
    logic                            saturated;
    logic                            last;

    modport source (output valid, out_row, out_col, product_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, product_value, saturated, last,
                    output ready);
endinterface

### design/mm_cfg_if.sv
// Configuration write channel of the matrix multiply block.
// Depends on mm_pkg for the index and data widths.
interface mm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mm_pkg::REG_W-1:0]  index;
    logic [mm_pkg::DIM_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/mm_mac.sv
// Multiply-accumulate unit: one registered 32x32 product and a wide accumulator.
// Scales the finished sum by the fraction width and saturates it to 32 bits.
// Depends on mm_pkg.
module mm_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [mm_pkg::VAL_W-1:0] i_a,
    input  logic signed [mm_pkg::VAL_W-1:0] i_b,
    input  mm_pkg::t_mac_ctl                i_ctl,
    output mm_pkg::t_mac_res                o_res
);

    logic signed [mm_pkg::PROD_W-1:0] r_prod;
    logic signed [mm_pkg::ACC_W-1:0]  r_acc;
    mm_pkg::t_mac_ctl                 r_prod_ctl;
    logic                             r_done;
    logic [mm_pkg::ACC_W-1:mm_pkg::FRAC_BITS+mm_pkg::VAL_W-1] top_bits;
    logic                             sat;

    // Control pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_ctl <= i_ctl;
            r_done     <= r_prod_ctl.valid & r_prod_ctl.last;
        end
    end

    // Product stage, then accumulate; the first term of a dot product restarts the sum.
    always_ff @(posedge i_clk) begin
        r_prod <= mm_pkg::PROD_W'(i_a) * mm_pkg::PROD_W'(i_b);
        if (r_prod_ctl.valid) begin
            if (r_prod_ctl.first) begin
                r_acc <= mm_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + mm_pkg::ACC_W'(r_prod);
            end
        end
    end

    // The scaled sum fits in 32 bits only if its sign bit and all bits above it agree.
    assign top_bits = r_acc[mm_pkg::ACC_W-1:mm_pkg::FRAC_BITS+mm_pkg::VAL_W-1];
    assign sat      = !((&top_bits) || (~|top_bits));

    always_comb begin
        o_res.done = r_done;
        o_res.sat  = sat;
        if (!sat) begin
            o_res.value = r_acc[mm_pkg::FRAC_BITS+mm_pkg::VAL_W-1:mm_pkg::FRAC_BITS];
        end else if (r_acc[mm_pkg::ACC_W-1]) begin
            o_res.value = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
        end else begin
            o_res.value = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
        end
    end

endmodule

### design/matrix_multiply.sv
// Top level of the fixed-point matrix multiply block: element stores, sequencer, output register.
// Depends on mm_pkg, mm_in_if, mm_out_if, mm_cfg_if and mm_mac.
//
//   Channel  Direction  Carries
//   i_in     sink       kind, row, col, value (load A, load B, compute)
//   o_out    source     out_row, out_col, product_value, saturated, last
//   i_cfg    sink       index, data (rows_a, inner_dim, cols_b)
//
// For each product element a compute makes inner_dim reads from the two element
// memories, one per cycle, then the multiply, accumulate and result load. No item is
// taken while a compute runs. A stalled output holds the sequencer before the next
// element. Reset clears control state and sets every dimension to 8; the element
// stores are not cleared.
module matrix_multiply (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mm_in_if.sink    i_in,
    mm_out_if.source o_out,
    mm_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [mm_pkg::DIM_W-1:0] r_rows_a;
    logic [mm_pkg::DIM_W-1:0] r_inner_dim;
    logic [mm_pkg::DIM_W-1:0] r_cols_b;
    logic [mm_pkg::DIM_W-1:0] nr;
    logic [mm_pkg::DIM_W-1:0] nk;
    logic [mm_pkg::DIM_W-1:0] nc;

    logic [mm_pkg::IDX_W-1:0] r_i;
    logic [mm_pkg::IDX_W-1:0] r_j;
    logic [mm_pkg::IDX_W-1:0] r_k;

    logic [mm_pkg::VAL_W-1:0] r_a_mem [mm_pkg::MEM_DEPTH];
    logic [mm_pkg::VAL_W-1:0] r_b_mem [mm_pkg::MEM_DEPTH];
    logic [mm_pkg::VAL_W-1:0] r_a_q;
    logic [mm_pkg::VAL_W-1:0] r_b_q;

    logic                     in_xfer;
    logic                     row_in_a;
    logic                     col_in_a;
    logic                     row_in_b;
    logic                     col_in_b;
    logic                     k_last;
    logic                     j_last;
    logic                     i_last;
    logic                     out_free;

    mm_pkg::t_mac_ctl         n_ctl;
    mm_pkg::t_mac_ctl         r_ctl;
    mm_pkg::t_mac_res         mac_res;

    logic                     r_out_v;
    logic [mm_pkg::IDX_W-1:0] r_out_row;
    logic [mm_pkg::IDX_W-1:0] r_out_col;
    logic [mm_pkg::VAL_W-1:0] r_out_val;
    logic                     r_out_sat;
    logic                     r_out_last;

    // Effective shape.
    assign nr = mm_pkg::clamp_dim(r_rows_a);
    assign nk = mm_pkg::clamp_dim(r_inner_dim);
    assign nc = mm_pkg::clamp_dim(r_cols_b);

    // Configuration writes; a register index beyond the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mm_pkg::DIM_RESET;
            r_inner_dim <= mm_pkg::DIM_RESET;
            r_cols_b    <= mm_pkg::DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mm_pkg::REG_ROWS_A:    r_rows_a    <= i_cfg.data;
                mm_pkg::REG_INNER_DIM: r_inner_dim <= i_cfg.data;
                mm_pkg::REG_COLS_B:    r_cols_b    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input transfers are taken only while no compute runs.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && (r_state == S_IDLE);

    assign row_in_a = {1'b0, i_in.row} < nr;
    assign col_in_a = {1'b0, i_in.col} < nk;
    assign row_in_b = {1'b0, i_in.row} < nk;
    assign col_in_b = {1'b0, i_in.col} < nc;

    // Element memories: loads write, the sequencer reads A(i,k) and B(k,j).
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in.kind == mm_pkg::KIND_LOAD_A) && row_in_a && col_in_a) begin
            r_a_mem[{i_in.row, i_in.col}] <= i_in.value;
        end
        if (in_xfer && (i_in.kind == mm_pkg::KIND_LOAD_B) && row_in_b && col_in_b) begin
            r_b_mem[{i_in.row, i_in.col}] <= i_in.value;
        end
        r_a_q <= r_a_mem[{r_i, r_k}];
        r_b_q <= r_b_mem[{r_k, r_j}];
    end

    // Read pair control, aligned with the registered memory data.
    assign k_last = ({1'b0, r_k} == nk - 1'b1);
    assign j_last = ({1'b0, r_j} == nc - 1'b1);
    assign i_last = ({1'b0, r_i} == nr - 1'b1);

    always_comb begin
        n_ctl.valid = (r_state == S_ISSUE);
        n_ctl.first = (r_k == '0);
        n_ctl.last  = k_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_a_q),
        .i_b     (r_b_q),
        .i_ctl   (r_ctl),
        .o_res   (mac_res)
    );

    // The output register can take a new result when empty or being emptied.
    assign out_free = !r_out_v || o_out.ready;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && o_out.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.kind == mm_pkg::KIND_COMPUTE)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (mac_res.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_row  <= r_i;
                        r_out_col  <= r_j;
                        r_out_val  <= mac_res.value;
                        r_out_sat  <= mac_res.sat;
                        r_out_last <= i_last && j_last;
                        if (j_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_val;
    assign o_out.saturated     = r_out_sat;
    assign o_out.last          = r_out_last;

endmodule

### tb/mm_checker.sv
`timescale 1ns / 100ps
// Result checker for the matrix multiply block: watches the item, result and register
// channels, predicts every product element and compares it with what the block sends.
// Depends on mm_pkg and the mm_in_if, mm_out_if and mm_cfg_if interfaces.
module mm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mm_in_if     i_in,
    mm_out_if    i_out,
    mm_cfg_if    i_cfg,
    output int   o_mismatches,
    output int   o_outstanding
);

    // Dot products of up to MAX_DIM full 64-bit terms need a few guard bits.
    localparam int SUM_W  = 2 * mm_pkg::VAL_W + 6;
    localparam int TERM_W = 2 * mm_pkg::VAL_W;
    localparam logic signed [SUM_W-1:0] POS_LIMIT =
        (SUM_W'(1) << (mm_pkg::VAL_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] NEG_LIMIT = -(SUM_W'(1) << (mm_pkg::VAL_W - 1));

    typedef struct {
        logic [mm_pkg::IDX_W-1:0]        row;
        logic [mm_pkg::IDX_W-1:0]        col;
        logic signed [mm_pkg::VAL_W-1:0] value;
        logic                            sat;
        logic                            last;
    } t_product_elem;

    t_product_elem                   product_q [$];
    logic signed [mm_pkg::VAL_W-1:0] a_mat [mm_pkg::MEM_DEPTH];
    logic signed [mm_pkg::VAL_W-1:0] b_mat [mm_pkg::MEM_DEPTH];
    logic [mm_pkg::DIM_W-1:0]        rows_a_reg;
    logic [mm_pkg::DIM_W-1:0]        inner_reg;
    logic [mm_pkg::DIM_W-1:0]        cols_b_reg;
    int                              mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    // A dimension of zero acts as one, anything above the maximum as the maximum.
    function automatic int active_dim(input logic [mm_pkg::DIM_W-1:0] d);
        if (d == '0) begin
            return 1;
        end
        if (d > mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) begin
            return mm_pkg::MAX_DIM;
        end
        return int'(d);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("mm_checker: %0t ns: %s", $time, what);
    endtask

    // Queue the whole product in row-major order, each element floored and clipped.
    task automatic predict_product();
        int                      n_rows;
        int                      n_inner;
        int                      n_cols;
        logic signed [SUM_W-1:0] dot;
        logic signed [SUM_W-1:0] scaled;
        logic signed [TERM_W-1:0] term;
        t_product_elem           elem;
        n_rows  = active_dim(rows_a_reg);
        n_inner = active_dim(inner_reg);
        n_cols  = active_dim(cols_b_reg);
        for (int r = 0; r < n_rows; r++) begin
            for (int c = 0; c < n_cols; c++) begin
                dot = '0;
                for (int k = 0; k < n_inner; k++) begin
                    term = TERM_W'(a_mat[r * mm_pkg::MAX_DIM + k]) *
                           TERM_W'(b_mat[k * mm_pkg::MAX_DIM + c]);
                    dot  = dot + SUM_W'(term);
                end
                scaled   = dot >>> mm_pkg::FRAC_BITS;
                elem.row = mm_pkg::IDX_W'(r);
                elem.col = mm_pkg::IDX_W'(c);
                elem.sat = 1'b1;
                if (scaled > POS_LIMIT) begin
                    elem.value = {1'b0, {(mm_pkg::VAL_W - 1){1'b1}}};
                end else if (scaled < NEG_LIMIT) begin
                    elem.value = {1'b1, {(mm_pkg::VAL_W - 1){1'b0}}};
                end else begin
                    elem.value = scaled[mm_pkg::VAL_W-1:0];
                    elem.sat   = 1'b0;
                end
                elem.last = (r == n_rows - 1) && (c == n_cols - 1);
                product_q.push_back(elem);
            end
        end
    endtask

    // Compare one result transfer against the oldest expected element.
    task automatic check_element();
        t_product_elem want;
        if (product_q.size() == 0) begin
            report_mismatch($sformatf("result (%0d,%0d) = %h with none expected",
                                      i_out.out_row, i_out.out_col, i_out.product_value));
        end else begin
            want = product_q.pop_front();
            if (i_out.out_row !== want.row) begin
                report_mismatch($sformatf("out_row %0d, expected %0d",
                                          i_out.out_row, want.row));
            end
            if (i_out.out_col !== want.col) begin
                report_mismatch($sformatf("out_col %0d, expected %0d",
                                          i_out.out_col, want.col));
            end
            if (i_out.product_value !== want.value) begin
                report_mismatch($sformatf("(%0d,%0d) product_value %h, expected %h",
                                          want.row, want.col, i_out.product_value,
                                          want.value));
            end
            if (i_out.saturated !== want.sat) begin
                report_mismatch($sformatf("(%0d,%0d) saturated %b, expected %b",
                                          want.row, want.col, i_out.saturated, want.sat));
            end
            if (i_out.last !== want.last) begin
                report_mismatch($sformatf("(%0d,%0d) last %b, expected %b",
                                          want.row, want.col, i_out.last, want.last));
            end
        end
    endtask

    // Follow every transfer on the three channels at the clock edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a_reg = mm_pkg::DIM_RESET;
            inner_reg  = mm_pkg::DIM_RESET;
            cols_b_reg = mm_pkg::DIM_RESET;
            product_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_element();
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    mm_pkg::REG_ROWS_A:    rows_a_reg = i_cfg.data;
                    mm_pkg::REG_INNER_DIM: inner_reg  = i_cfg.data;
                    mm_pkg::REG_COLS_B:    cols_b_reg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.kind)
                    mm_pkg::KIND_LOAD_A: begin
                        if (int'(i_in.row) < active_dim(rows_a_reg) &&
                            int'(i_in.col) < active_dim(inner_reg)) begin
                            a_mat[int'(i_in.row) * mm_pkg::MAX_DIM + int'(i_in.col)] =
                                i_in.value;
                        end
                    end
                    mm_pkg::KIND_LOAD_B: begin
                        if (int'(i_in.row) < active_dim(inner_reg) &&
                            int'(i_in.col) < active_dim(cols_b_reg)) begin
                            b_mat[int'(i_in.row) * mm_pkg::MAX_DIM + int'(i_in.col)] =
                                i_in.value;
                        end
                    end
                    mm_pkg::KIND_COMPUTE: begin
                        predict_product();
                    end
                    default: ;
                endcase
            end
        end
        o_outstanding <= product_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the matrix multiply block: clock, reset, item and register
// stimulus, result-side stalls and the verdict.
// Depends on mm_pkg, the channel interfaces, matrix_multiply and mm_checker.
module tb;

    localparam logic [mm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [mm_pkg::REG_W-1:0]  REG_SPARE  = 2'd3;
    localparam logic [mm_pkg::VAL_W-1:0]  MAX_POS    = {1'b0, {(mm_pkg::VAL_W - 1){1'b1}}};
    localparam logic [mm_pkg::VAL_W-1:0]  MIN_NEG    = {1'b1, {(mm_pkg::VAL_W - 1){1'b0}}};
    localparam logic [mm_pkg::VAL_W-1:0]  FIX_ONE    =
        mm_pkg::VAL_W'(1) << mm_pkg::FRAC_BITS;
    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_PERCENT = 9;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatch_count;
    int   results_outstanding;
    int   item_count;
    int   eff_rows;
    int   eff_inner;
    int   eff_cols;
    bit   wide_values;
    bit   a_filled [mm_pkg::MEM_DEPTH];
    bit   b_filled [mm_pkg::MEM_DEPTH];

    mm_in_if  in_ch ();
    mm_out_if out_ch ();
    mm_cfg_if cfg_ch ();

    matrix_multiply u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mm_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg         (cfg_ch),
        .o_mismatches  (mismatch_count),
        .o_outstanding (results_outstanding)
    );

    // 100 MHz clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: FAIL");
        $finish;
    end

    // The result side stalls at random except during the calm stretch.
    always @(posedge clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= STALL_PERCENT);
    end

    function automatic int shape_dim(input logic [mm_pkg::DIM_W-1:0] d);
        if (d == '0) begin
            return 1;
        end
        return (d > mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) ? mm_pkg::MAX_DIM : int'(d);
    endfunction

    // Mostly fractional values of modest size; wide mode adds full-range and extreme values.
    function automatic logic [mm_pkg::VAL_W-1:0] rand_value(input bit wide);
        logic signed [mm_pkg::VAL_W-1:0] v;
        v = $urandom;
        if (wide && $urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0:       v = MAX_POS;
                1:       v = MIN_NEG;
                2:       v = '1;
                default: v = '0;
            endcase
        end else if (!wide || $urandom_range(1) == 1) begin
            v = v >>> $urandom_range(20, 8);
        end
        return v;
    endfunction

    function automatic logic [mm_pkg::DIM_W-1:0] rand_dim();
        case ($urandom_range(7))
            0:       return mm_pkg::DIM_W'($urandom_range(15, 9));
            1:       return '0;
            2, 3:    return mm_pkg::DIM_W'($urandom_range(8, 5));
            default: return mm_pkg::DIM_W'($urandom_range(4, 1));
        endcase
    endfunction

    // Present one item and hold it until the transfer, sometimes after a short gap.
    task automatic send_item(input logic [mm_pkg::KIND_W-1:0] kind,
                             input logic [mm_pkg::IDX_W-1:0] row,
                             input logic [mm_pkg::IDX_W-1:0] col,
                             input logic [mm_pkg::VAL_W-1:0] value);
        if (!calm && $urandom_range(99) < STALL_PERCENT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.value <= value;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Loads inside the shape are tracked so that no compute reads an unwritten element.
    task automatic load_elem(input bit to_b, input int row, input int col,
                             input logic [mm_pkg::VAL_W-1:0] value);
        bit fits;
        fits = to_b ? (row < eff_inner && col < eff_cols) : (row < eff_rows && col < eff_inner);
        send_item(to_b ? mm_pkg::KIND_LOAD_B : mm_pkg::KIND_LOAD_A,
                  mm_pkg::IDX_W'(row), mm_pkg::IDX_W'(col), value);
        if (fits) begin
            if (to_b) begin
                b_filled[row * mm_pkg::MAX_DIM + col] = 1'b1;
            end else begin
                a_filled[row * mm_pkg::MAX_DIM + col] = 1'b1;
            end
            item_count++;
        end
    endtask

    // An item the block must ignore: a load past the shape edge or the spare kind.
    task automatic noise_item();
        bit to_b;
        bit spare;
        int row;
        int col;
        int lim_r;
        int lim_c;
        to_b  = $urandom_range(1);
        row   = $urandom_range(mm_pkg::MAX_DIM - 1);
        col   = $urandom_range(mm_pkg::MAX_DIM - 1);
        lim_r = to_b ? eff_inner : eff_rows;
        lim_c = to_b ? eff_cols : eff_inner;
        spare = 1'b0;
        if (lim_r < mm_pkg::MAX_DIM && (lim_c == mm_pkg::MAX_DIM || $urandom_range(1) == 1)) begin
            row = $urandom_range(mm_pkg::MAX_DIM - 1, lim_r);
        end else if (lim_c < mm_pkg::MAX_DIM) begin
            col = $urandom_range(mm_pkg::MAX_DIM - 1, lim_c);
        end else begin
            spare = 1'b1;
        end
        if (spare || $urandom_range(3) == 0) begin
            send_item(KIND_SPARE, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom), $urandom);
        end else begin
            send_item(to_b ? mm_pkg::KIND_LOAD_B : mm_pkg::KIND_LOAD_A,
                      mm_pkg::IDX_W'(row), mm_pkg::IDX_W'(col), $urandom);
        end
    endtask

    // Load every element of A and B in the shape, or only those never written.
    task automatic fill_shape(input bit only_missing);
        for (int r = 0; r < eff_rows; r++) begin
            for (int c = 0; c < eff_inner; c++) begin
                if (!only_missing || !a_filled[r * mm_pkg::MAX_DIM + c]) begin
                    if (!only_missing && $urandom_range(99) < 8) begin
                        noise_item();
                    end
                    load_elem(1'b0, r, c, rand_value(wide_values));
                end
            end
        end
        for (int r = 0; r < eff_inner; r++) begin
            for (int c = 0; c < eff_cols; c++) begin
                if (!only_missing || !b_filled[r * mm_pkg::MAX_DIM + c]) begin
                    if (!only_missing && $urandom_range(99) < 8) begin
                        noise_item();
                    end
                    load_elem(1'b1, r, c, rand_value(wide_values));
                end
            end
        end
    endtask

    task automatic compute_product();
        fill_shape(1'b1);
        send_item(mm_pkg::KIND_COMPUTE, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                  $urandom);
        item_count++;
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mm_pkg::REG_W-1:0] index,
                             input logic [mm_pkg::DIM_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Reshape only while the block is idle; a write to the spare index now and then.
    task automatic set_shape(input logic [mm_pkg::DIM_W-1:0] rows,
                             input logic [mm_pkg::DIM_W-1:0] inner,
                             input logic [mm_pkg::DIM_W-1:0] cols);
        wait_idle();
        write_reg(mm_pkg::REG_ROWS_A, rows);
        write_reg(mm_pkg::REG_INNER_DIM, inner);
        write_reg(mm_pkg::REG_COLS_B, cols);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_SPARE, mm_pkg::DIM_W'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        eff_rows  = shape_dim(rows);
        eff_inner = shape_dim(inner);
        eff_cols  = shape_dim(cols);
    endtask

    initial begin : stimulus
        int phase;
        int rounds;
        int edits;
        int base_count;
        bit to_b;
        rst_n        <= 1'b0;
        calm         <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.kind   <= mm_pkg::KIND_LOAD_A;
        in_ch.row    <= '0;
        in_ch.col    <= '0;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= mm_pkg::REG_ROWS_A;
        cfg_ch.data  <= mm_pkg::DIM_RESET;
        eff_rows     = mm_pkg::MAX_DIM;
        eff_inner    = mm_pkg::MAX_DIM;
        eff_cols     = mm_pkg::MAX_DIM;
        item_count   = 0;
        wide_values  = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-element products for clipping, flooring and ignored items.
        set_shape(4'd1, 4'd1, 4'd1);
        load_elem(1'b0, 0, 0, MAX_POS);
        load_elem(1'b1, 0, 0, MAX_POS);
        compute_product();
        load_elem(1'b1, 0, 0, MIN_NEG);
        compute_product();
        load_elem(1'b0, 0, 0, MIN_NEG);
        compute_product();
        load_elem(1'b0, 0, 0, '1);
        load_elem(1'b1, 0, 0, FIX_ONE);
        compute_product();
        // A tiny negative product must floor to minus one step.
        load_elem(1'b1, 0, 0, mm_pkg::VAL_W'(1));
        compute_product();
        // Out-of-shape loads and the spare kind leave the stores alone.
        load_elem(1'b0, 7, 7, MAX_POS);
        load_elem(1'b1, 0, 7, MAX_POS);
        send_item(KIND_SPARE, '1, '1, MAX_POS);
        compute_product();
        set_shape(4'd0, 4'd0, 4'd0);
        load_elem(1'b0, 0, 0, '0);
        compute_product();

        // Random: fill the shape, compute, then edit and recompute a few times.
        // The first random phase is the calm stretch with no idling on either side.
        base_count = item_count;
        phase = 0;
        while (item_count - base_count < RANDOM_ITEMS) begin
            case (phase)
                0:       set_shape(4'd15, 4'd15, 4'd15);
                1:       set_shape(4'd8, 4'd1, 4'd8);
                2:       set_shape(4'd1, 4'd8, 4'd1);
                3:       set_shape(4'd0, 4'd9, 4'd0);
                default: set_shape(rand_dim(), rand_dim(), rand_dim());
            endcase
            calm        <= (phase == 0);
            wide_values = (phase < 2) || ($urandom_range(9) < 3);
            rounds      = $urandom_range(3, 1);
            fill_shape(1'b0);
            compute_product();
            for (int n = 1; n < rounds && item_count - base_count < RANDOM_ITEMS; n++) begin
                edits = $urandom_range(eff_rows * eff_inner + eff_inner * eff_cols, 1);
                repeat (edits) begin
                    to_b = $urandom_range(1);
                    if ($urandom_range(99) < 10) begin
                        noise_item();
                    end else if (to_b) begin
                        load_elem(1'b1, $urandom_range(eff_inner - 1),
                                  $urandom_range(eff_cols - 1), rand_value(wide_values));
                    end else begin
                        load_elem(1'b0, $urandom_range(eff_rows - 1),
                                  $urandom_range(eff_inner - 1), rand_value(wide_values));
                    end
                end
                compute_product();
                // Back-to-back computes on unchanged stores.
                if ($urandom_range(3) == 0) begin
                    compute_product();
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
design/mm_pkg.sv
design/mm_in_if.sv
design/mm_out_if.sv
design/mm_cfg_if.sv
design/mm_mac.sv
design/matrix_multiply.sv
tb/mm_checker.sv
tb/tb.sv
